// File: hdl/wmst_pkg.sv
package wmst_pkg;

    // window depth in bytes and the width of a count over it
    localparam int WIN   = 6;
    localparam int CNT_W = $clog2(WIN + 1);

    localparam logic [CNT_W-1:0] WIN_FULL = CNT_W'(WIN);

    // style codes
    localparam logic [2:0] ST_A = 3'd0;  // plain
    localparam logic [2:0] ST_B = 3'd1;  // pre
    localparam logic [2:0] ST_C = 3'd2;  // link
    localparam logic [2:0] ST_D = 3'd3;  // italic
    localparam logic [2:0] ST_E = 3'd4;  // marker
    localparam logic [2:0] ST_F = 3'd5;  // bold
    localparam logic [2:0] ST_G = 3'd6;  // target
    localparam logic [2:0] ST_H = 3'd7;  // html

    // single characters
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_NONE  = 8'h00;

    // byte window, element 0 is the head
    typedef logic [0:WIN-1][7:0] bytes_t;

    // marker patterns, left aligned and zero padded
    localparam bytes_t PAT_PRE     = {"<pre>", 8'h00};
    localparam bytes_t PAT_PRE_END = "</pre>";
    localparam bytes_t PAT_DASH    = {" - ", 24'h0};
    localparam bytes_t PAT_STAR1   = {" * ", 24'h0};
    localparam bytes_t PAT_STAR2   = {" ** ", 16'h0};
    localparam bytes_t PAT_STAR3   = {" *** ", 8'h00};
    localparam bytes_t PAT_LINK    = {"[[", 32'h0};
    localparam bytes_t PAT_LINK_END = {"]]", 32'h0};
    localparam bytes_t PAT_TT      = {"<tt>", 16'h0};
    localparam bytes_t PAT_TT_END  = {"</tt>", 8'h00};
    localparam bytes_t PAT_TABLE   = {"||", 32'h0};
    localparam bytes_t PAT_ESC     = {8'h5c, "&", 32'h0};
    localparam bytes_t PAT_ITALIC  = {"//", 32'h0};
    localparam bytes_t PAT_BOLD    = {"**", 32'h0};
    localparam bytes_t PAT_TARGET  = {"##", 32'h0};

    // one head decision
    typedef struct packed {
        logic [2:0]       style;
        logic [CNT_W-1:0] len;
        logic [2:0]       nxt;
        logic             marker;
    } dec_t;

    // load of a burst of equal results into the output stage
    typedef struct packed {
        logic             load;
        logic [2:0]       style;
        logic [CNT_W-1:0] len;
        logic             run_end;
    } burst_t;

endpackage

// File: hdl/wmst_if.sv
interface wmst_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       first;
    logic [2:0] start_style;
    logic       last;

    modport source (output valid, char_code, first, start_style, last, input ready);
    modport sink (input valid, char_code, first, start_style, last, output ready);
endinterface

interface wmst_style_if;
    logic       valid;
    logic       ready;
    logic [2:0] style_code;
    logic       run_end;

    modport source (output valid, style_code, run_end, input ready);
    modport sink (input valid, style_code, run_end, output ready);
endinterface

// File: hdl/wmst_decide.sv
module wmst_decide (
    input  wmst_pkg::bytes_t           win,
    input  logic [wmst_pkg::CNT_W-1:0] cnt,
    input  logic [7:0]                 prev,
    input  logic [2:0]                 run,
    input  logic                       line,
    output wmst_pkg::dec_t             dec
);

    // pattern match on the head of the window, never past the held bytes
    function automatic logic hit(
        input wmst_pkg::bytes_t           w,
        input logic [wmst_pkg::CNT_W-1:0] n,
        input wmst_pkg::bytes_t           p,
        input logic [wmst_pkg::CNT_W-1:0] len
    );
        logic r;
        r = (len <= n);
        for (int i = 0; i < wmst_pkg::WIN; i++)
        begin
            if ((wmst_pkg::CNT_W'(i) < len) && (w[i] != p[i]))
            begin
                r = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic wmst_pkg::dec_t mk(
        input logic [2:0]                 style,
        input logic [wmst_pkg::CNT_W-1:0] len,
        input logic [2:0]                 nxt
    );
        wmst_pkg::dec_t d;
        d.style  = style;
        d.len    = len;
        d.nxt    = nxt;
        d.marker = 1'b1;
        return d;
    endfunction

    logic esc;

    always_comb
    begin
        esc = (prev == wmst_pkg::CH_BSL);

        // plain byte takes the running style
        dec.style  = run;
        dec.len    = wmst_pkg::CNT_W'(1);
        dec.nxt    = run;
        dec.marker = 1'b0;

        if (line && hit(win, cnt, wmst_pkg::PAT_PRE, 3'd5))
        begin
            dec = mk(wmst_pkg::ST_B, 3'd5, wmst_pkg::ST_B);
        end
        else if (line && hit(win, cnt, wmst_pkg::PAT_PRE_END, 3'd6))
        begin
            dec = mk(wmst_pkg::ST_B, 3'd6, wmst_pkg::ST_A);
        end
        else if (line && hit(win, cnt, wmst_pkg::PAT_DASH, 3'd3))
        begin
            dec = mk(wmst_pkg::ST_E, 3'd3, wmst_pkg::ST_A);
        end
        else if (line && hit(win, cnt, wmst_pkg::PAT_STAR1, 3'd3))
        begin
            dec = mk(wmst_pkg::ST_E, 3'd3, wmst_pkg::ST_A);
        end
        else if (line && hit(win, cnt, wmst_pkg::PAT_STAR2, 3'd4))
        begin
            dec = mk(wmst_pkg::ST_E, 3'd4, wmst_pkg::ST_A);
        end
        else if (line && hit(win, cnt, wmst_pkg::PAT_STAR3, 3'd5))
        begin
            dec = mk(wmst_pkg::ST_E, 3'd5, wmst_pkg::ST_A);
        end
        else if (hit(win, cnt, wmst_pkg::PAT_LINK, 3'd2))
        begin
            dec = mk(wmst_pkg::ST_E, 3'd2, wmst_pkg::ST_C);
        end
        else if (hit(win, cnt, wmst_pkg::PAT_LINK_END, 3'd2))
        begin
            dec = mk(wmst_pkg::ST_E, 3'd2, wmst_pkg::ST_A);
        end
        else if (hit(win, cnt, wmst_pkg::PAT_TT, 3'd4))
        begin
            dec = mk(wmst_pkg::ST_E, 3'd4, wmst_pkg::ST_B);
        end
        else if (hit(win, cnt, wmst_pkg::PAT_TT_END, 3'd5))
        begin
            dec = mk(wmst_pkg::ST_E, 3'd5, wmst_pkg::ST_A);
        end
        else if ((win[0] == wmst_pkg::CH_LT) && !esc)
        begin
            dec = mk(wmst_pkg::ST_H, 3'd1, wmst_pkg::ST_H);
        end
        else if ((win[0] == wmst_pkg::CH_GT) && !esc && (run == wmst_pkg::ST_H))
        begin
            dec = mk(wmst_pkg::ST_H, 3'd1, wmst_pkg::ST_A);
        end
        else if (hit(win, cnt, wmst_pkg::PAT_TABLE, 3'd2))
        begin
            dec = mk(wmst_pkg::ST_E, 3'd2, wmst_pkg::ST_A);
        end
        else if (hit(win, cnt, wmst_pkg::PAT_ESC, 3'd2))
        begin
            dec = mk(wmst_pkg::ST_E, 3'd2, wmst_pkg::ST_A);
        end
        else if (hit(win, cnt, wmst_pkg::PAT_ITALIC, 3'd2))
        begin
            // outside italic, after a colon this is a url, not an italic toggle
            if (run == wmst_pkg::ST_D)
            begin
                dec = mk(wmst_pkg::ST_E, 3'd2, wmst_pkg::ST_A);
            end
            else if (prev != wmst_pkg::CH_COLON)
            begin
                dec = mk(wmst_pkg::ST_E, 3'd2, wmst_pkg::ST_D);
            end
        end
        else if (hit(win, cnt, wmst_pkg::PAT_BOLD, 3'd2))
        begin
            dec = mk(wmst_pkg::ST_E, 3'd2,
                     (run == wmst_pkg::ST_F) ? wmst_pkg::ST_A : wmst_pkg::ST_F);
        end
        else if (hit(win, cnt, wmst_pkg::PAT_TARGET, 3'd2))
        begin
            dec = mk(wmst_pkg::ST_E, 3'd2,
                     (run == wmst_pkg::ST_G) ? wmst_pkg::ST_A : wmst_pkg::ST_G);
        end
    end

endmodule

// File: hdl/wmst_window.sv
module wmst_window (
    input  logic                clk,
    input  logic                rst_n,
    wmst_text_if.sink           text,
    input  logic                free,
    output wmst_pkg::burst_t    load
);

    wmst_pkg::bytes_t           win_reg, win_next;
    logic [wmst_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]                 prev_reg, prev_next;
    logic [2:0]                 run_reg, run_next;
    logic                       line_reg, line_next;
    logic                       flush_reg, flush_next;

    wmst_pkg::dec_t             dec;
    wmst_pkg::bytes_t           win_a;
    logic [wmst_pkg::CNT_W-1:0] cnt_a, cnt_b;
    logic                       go;
    logic                       acc;
    logic [7:0]                 tail;

    wmst_decide u_decide (
        .win  (win_reg),
        .cnt  (cnt_reg),
        .prev (prev_reg),
        .run  (run_reg),
        .line (line_reg),
        .dec  (dec)
    );

    always_comb
    begin
        // decide on a full window or a draining flush, only when free
        go = free && (flush_reg ? (cnt_reg != '0) : (cnt_reg == wmst_pkg::WIN_FULL));

        win_a     = win_reg;
        cnt_a     = cnt_reg;
        prev_next = prev_reg;
        run_next  = run_reg;
        line_next = line_reg;
        tail      = win_reg[0];

        if (go)
        begin
            win_a = win_reg << {dec.len, 3'b000};
            cnt_a = cnt_reg - dec.len;
            for (int i = 0; i < wmst_pkg::WIN; i++)
            begin
                if (wmst_pkg::CNT_W'(i + 1) == dec.len)
                begin
                    tail = win_reg[i];
                end
            end
            prev_next = tail;
            run_next  = dec.nxt;
            line_next = !dec.marker && (tail == wmst_pkg::CH_NL);
        end

        text.ready = !flush_reg && ((cnt_reg != wmst_pkg::WIN_FULL) || go);
        acc        = text.valid && text.ready;

        cnt_b    = cnt_a;
        win_next = win_a;
        cnt_next = cnt_a;
        if (acc)
        begin
            // a new run drops whatever an earlier run left undecided
            if (text.first)
            begin
                cnt_b     = '0;
                run_next  = text.start_style;
                line_next = 1'b1;
                prev_next = wmst_pkg::CH_NONE;
            end
            for (int i = 0; i < wmst_pkg::WIN; i++)
            begin
                if (wmst_pkg::CNT_W'(i) == cnt_b)
                begin
                    win_next[i] = text.char_code;
                end
            end
            cnt_next = cnt_b + 1'b1;
        end

        flush_next = flush_reg;
        if (acc)
        begin
            flush_next = text.last;
        end
        else if (go && (cnt_a == '0))
        begin
            flush_next = 1'b0;
        end

        load.load    = go;
        load.style   = dec.style;
        load.len     = dec.len;
        load.run_end = flush_reg && (cnt_a == '0);
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            prev_reg  <= wmst_pkg::CH_NONE;
            run_reg   <= wmst_pkg::ST_A;
            line_reg  <= 1'b1;
            flush_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            prev_reg  <= prev_next;
            run_reg   <= run_next;
            line_reg  <= line_next;
            flush_reg <= flush_next;
        end
    end

endmodule

// File: hdl/wmst_burst.sv
module wmst_burst (
    input  logic             clk,
    input  logic             rst_n,
    input  wmst_pkg::burst_t load,
    output logic             free,
    wmst_style_if.source     styles
);

    logic [wmst_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [2:0]                 style_reg, style_next;
    logic                       end_reg, end_next;
    logic                       take;

    always_comb
    begin
        styles.valid      = (cnt_reg != '0);
        styles.style_code = style_reg;
        // end flag rides only on the final result of the burst
        styles.run_end    = end_reg && (cnt_reg == wmst_pkg::CNT_W'(1));

        take = styles.valid && styles.ready;
        free = (cnt_reg == '0) || ((cnt_reg == wmst_pkg::CNT_W'(1)) && styles.ready);

        cnt_next   = take ? (cnt_reg - 1'b1) : cnt_reg;
        style_next = style_reg;
        end_next   = end_reg;
        if (load.load)
        begin
            cnt_next   = load.len;
            style_next = load.style;
            end_next   = load.run_end;
        end
    end

    always_ff @(posedge clk)
    begin
        style_reg <= style_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            end_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            end_reg <= end_next;
        end
    end

endmodule

// File: hdl/wiki_markup_style_tagger_top.sv
// timing: a byte is decided once five later bytes of its run are held and the output
//   stage is free, or in the drain after the run's last byte; its style shows next cycle
// throughput: one request per cycle while styles.ready stays high; a marker of k bytes
//   leaves as k results from the output stage, and a run's last request holds input off
//   while the window drains, each decision waiting for a free output stage
// reset: rst_n clears window count, running style, line flag and output stage
module wiki_markup_style_tagger_top (
    input  logic        clk,
    input  logic        rst_n,
    wmst_text_if.sink   text,
    wmst_style_if.source styles
);

    // the window holds up to six undecided bytes plus the running state:
    // running style, line start flag, the byte before the head, and a flush
    // flag set by the last byte of a run. each cycle the head is matched
    // against every marker pattern at once; the winning decision shifts the
    // window by its length and hands one burst to the output stage
    wmst_pkg::burst_t load;

    // high when the output stage can take a new burst this cycle, which
    // includes the cycle in which its final result is taken
    logic free;

    wmst_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text),
        .free  (free),
        .load  (load)
    );

    // output stage repeats the burst style once per marker byte, so the
    // input side keeps moving while results wait downstream
    wmst_burst u_burst (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .free   (free),
        .styles (styles)
    );

endmodule

// File: hdl/wmst_checker.sv
module wmst_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       text_valid,
    input logic       text_ready,
    input logic       text_last,
    input logic       styles_valid,
    input logic       styles_ready,
    input logic [2:0] style_code,
    input logic       run_end
);

    // the end flag never shows without a result
    a_end_valid: assert property (@(posedge clk) disable iff (!rst_n)
        run_end |-> styles_valid)
        else $error("run_end without valid result");

    // a stalled result keeps its style and end flag
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        styles_valid && !styles_ready |=>
            styles_valid && $stable(style_code) && $stable(run_end))
        else $error("stalled result changed");

    // the last byte of a run holds off input while the window drains
    a_flush: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && text_ready && text_last |=> !text_ready)
        else $error("input taken during flush");

endmodule

bind wiki_markup_style_tagger_top wmst_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .text_valid   (text.valid),
    .text_ready   (text.ready),
    .text_last    (text.last),
    .styles_valid (styles.valid),
    .styles_ready (styles.ready),
    .style_code   (styles.style_code),
    .run_end      (styles.run_end)
);
